@@ design/vns_pkg.sv @@
// shared constants, codes and command/status structs for the voxel smoother
// no dependencies
package vns_pkg;

  localparam int MAX_EXTENT  = 32;
  localparam int STORE_DEPTH = 32768;

  localparam int SIZE_W     = 6;
  localparam int COORD_W    = $clog2(MAX_EXTENT);
  localparam int IDX_W      = $clog2(STORE_DEPTH);
  localparam int SXY_W      = $clog2(MAX_EXTENT * MAX_EXTENT + 1);
  localparam int TOT_W      = $clog2(MAX_EXTENT * MAX_EXTENT * MAX_EXTENT + 1);
  localparam int VOX_W      = 16;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 21;
  localparam int RSUM_W     = 37;
  localparam int DIV_W      = 40;
  localparam int DCNT_W     = $clog2(DIV_W);
  localparam int MODE_W     = 2;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_HOT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HARM = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [1:0] DIV_X     = 2'd0;
  localparam logic [1:0] DIV_Y     = 2'd1;
  localparam logic [1:0] DIV_RECIP = 2'd2;
  localparam logic [1:0] DIV_FINAL = 2'd3;

  localparam logic [1:0] RES_V    = 2'd0;
  localparam logic [1:0] RES_ZERO = 2'd1;
  localparam logic [1:0] RES_QUOT = 2'd2;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       div_start;
    logic [1:0] div_op;
    logic       cap_x;
    logic       cap_yz;
    logic       setup;
    logic       acc;
    logic       recip_add;
    logic       nb_step;
    logic       prod;
    logic       res_load;
    logic [1:0] res_sel;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic              div_done;
    logic              need_recip;
    logic              nb_last;
    logic [MODE_W-1:0] mode;
    logic              lone;
    logic              hot;
    logic              npos_zero;
    logic              out_free;
  } dp_sts_t;

  function automatic logic [SIZE_W-1:0] clamp_extent(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_W'(MAX_EXTENT)) r = SIZE_W'(MAX_EXTENT);
    else r = s;
    return r;
  endfunction

endpackage

@@ design/vns_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module vns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ design/vns_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
// depends on vns_pkg
module vns_div import vns_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [DIV_W-1:0] rem
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem, quot[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], ge};
      rem  <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

endmodule

@@ design/vns_dp.sv @@
// datapath: config registers, indices, voxel store, neighbor walk, accumulators, output
// depends on vns_pkg, vns_ram, vns_div
module vns_dp import vns_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [VOX_W-1:0]      voxel_value,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [VOX_W-1:0]      smoothed_value,
  output logic                  last_voxel
);

  logic [MODE_W-1:0] filter_mode;
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [THR_W-1:0]  thresh;
  logic [SIZE_W-1:0] sx, sy, sz;
  logic [SXY_W-1:0]  sxy;
  logic [TOT_W-1:0]  total;

  logic [IDX_W-1:0]  load_index, output_index, work_idx;
  logic [IDX_W-1:0]  la, oi_eff;
  logic [TOT_W-1:0]  la_inc, wi_inc;

  logic [COORD_W-1:0] ix, iy, iz;
  logic [COORD_W-1:0] xlo, xhi, ylo, yhi, zlo, zhi;
  logic [COORD_W-1:0] nx, ny, nz;

  logic [SUM_W-1:0]   sum, rest;
  logic [CNT_W-1:0]   count, cm1, npos;
  logic [RSUM_W-1:0]  rsum;
  logic [VOX_W-1:0]   vc, res;
  logic [24:0]        pa;
  logic [28:0]        pb;

  logic [IDX_W-1:0]   rd_addr;
  logic [VOX_W-1:0]   ram_q;

  logic [DIV_W-1:0]   dvd, dsr, div_quot, div_rem;
  logic               div_done;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_HOT;
      size_x      <= SIZE_W'(MAX_EXTENT);
      size_y      <= SIZE_W'(MAX_EXTENT);
      size_z      <= SIZE_W'(MAX_EXTENT);
      thresh      <= THR_W'(80);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:   filter_mode <= cfg_data[MODE_W-1:0];
        REG_SIZE_X: size_x      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: size_y      <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: size_z      <= cfg_data[SIZE_W-1:0];
        REG_THRESH: thresh      <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign sx = clamp_extent(size_x);
  assign sy = clamp_extent(size_y);
  assign sz = clamp_extent(size_z);

  // grid size: x*y product registered from the extents, total registered from it
  always_ff @(posedge clk) begin
    sxy   <= SXY_W'(sx * sy);
    total <= TOT_W'(sxy * sz);
  end

  // load and output indices
  assign la     = ({1'b0, load_index} >= total) ? '0 : load_index;
  assign la_inc = {1'b0, la} + 1'b1;
  assign oi_eff = ({1'b0, output_index} >= total) ? '0 : output_index;
  assign wi_inc = {1'b0, work_idx} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index   <= '0;
      output_index <= '0;
    end else begin
      if (cmd.load) load_index <= (la_inc >= total) ? '0 : la_inc[IDX_W-1:0];
      if (cmd.emit) output_index <= (wi_inc >= total) ? '0 : wi_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) work_idx <= oi_eff;
  end

  vns_ram #(.WIDTH(VOX_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (la),
    .wdata (voxel_value),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign rd_addr = IDX_W'(nx) + IDX_W'(ny) * IDX_W'(sx) + IDX_W'(nz) * IDX_W'(sxy);

  // divider operand select
  assign rest = sum - SUM_W'(vc);
  assign cm1  = count - 1'b1;

  always_comb begin
    dvd = '0;
    dsr = DIV_W'(1);
    case (cmd.div_op)
      DIV_X: begin
        dvd = DIV_W'(oi_eff);
        dsr = DIV_W'(sx);
      end
      DIV_Y: begin
        dvd = DIV_W'(div_quot[IDX_W-1:0]);
        dsr = DIV_W'(sy);
      end
      DIV_RECIP: begin
        dvd = DIV_W'(64'h1_0000_0000);
        dsr = DIV_W'(ram_q);
      end
      default: begin
        if (filter_mode == MODE_HOT) begin
          dvd = DIV_W'(rest);
          dsr = DIV_W'(cm1);
        end else if (filter_mode == MODE_HARM) begin
          dvd = DIV_W'({npos, 32'h0});
          dsr = DIV_W'(rsum);
        end else begin
          dvd = DIV_W'(sum);
          dsr = DIV_W'(count);
        end
      end
    endcase
  end

  vns_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // centre coordinates and neighbor walk
  always_ff @(posedge clk) begin
    if (cmd.cap_x) ix <= div_rem[COORD_W-1:0];
    if (cmd.cap_yz) begin
      iy <= div_rem[COORD_W-1:0];
      iz <= div_quot[COORD_W-1:0];
    end
    if (cmd.setup) begin
      xlo <= (ix != '0) ? ix - 1'b1 : '0;
      ylo <= (iy != '0) ? iy - 1'b1 : '0;
      zlo <= (iz != '0) ? iz - 1'b1 : '0;
      xhi <= (({1'b0, ix} + 1'b1) < sx) ? ix + 1'b1 : ix;
      yhi <= (({1'b0, iy} + 1'b1) < sy) ? iy + 1'b1 : iy;
      zhi <= (({1'b0, iz} + 1'b1) < sz) ? iz + 1'b1 : iz;
      nx  <= (ix != '0) ? ix - 1'b1 : '0;
      ny  <= (iy != '0) ? iy - 1'b1 : '0;
      nz  <= (iz != '0) ? iz - 1'b1 : '0;
      sum   <= '0;
      count <= '0;
      rsum  <= '0;
      npos  <= '0;
    end else begin
      if (cmd.nb_step) begin
        if (nx != xhi) begin
          nx <= nx + 1'b1;
        end else begin
          nx <= xlo;
          if (ny != yhi) begin
            ny <= ny + 1'b1;
          end else begin
            ny <= ylo;
            nz <= nz + 1'b1;
          end
        end
      end
      if (cmd.acc) begin
        sum   <= sum + SUM_W'(ram_q);
        count <= count + 1'b1;
        if (nx == ix && ny == iy && nz == iz) vc <= ram_q;
      end
      if (cmd.recip_add) begin
        rsum <= rsum + div_quot[RSUM_W-1:0];
        npos <= npos + 1'b1;
      end
    end
  end

  // hot-spot test operands
  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      pa <= {21'(vc * cm1), 4'h0};
      pb <= 29'(thresh * rest);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_V:    res <= vc;
        RES_ZERO: res <= '0;
        default:  res <= (div_quot > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_quot[VOX_W-1:0];
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      smoothed_value <= res;
      last_voxel     <= (wi_inc >= total);
    end
  end

  always_comb begin
    sts            = '0;
    sts.div_done   = div_done;
    sts.need_recip = (filter_mode == MODE_HARM) && (ram_q != '0);
    sts.nb_last    = (nx == xhi) && (ny == yhi) && (nz == zhi);
    sts.mode       = filter_mode;
    sts.lone       = (count <= CNT_W'(1));
    sts.hot        = (29'(pa) > pb);
    sts.npos_zero  = (npos == '0);
    sts.out_free   = !result_valid || !result_stall;
  end

endmodule

@@ design/vns_ctrl.sv @@
// controller: sequences load, coordinate split, neighbor walk, final divide and output
// depends on vns_pkg
module vns_ctrl import vns_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    command,
  input  logic    cfg_write,
  input  dp_sts_t sts,
  output logic    item_stall,
  output dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CX    = 4'd1;
  localparam logic [3:0] S_CY    = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_ISSUE = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_RWAIT = 4'd6;
  localparam logic [3:0] S_FINAL = 4'd7;
  localparam logic [3:0] S_HCMP  = 4'd8;
  localparam logic [3:0] S_FWAIT = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state, state_next;
  logic [1:0] settle;
  logic       accept;

  // after reset or any configuration write, hold items off until grid size settles
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 2'd2;
    end else if (cfg_write) begin
      settle <= 2'd2;
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  assign item_stall = (state != S_IDLE) || (settle != '0);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start     = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_X;
            state_next    = S_CX;
          end
        end
      end
      S_CX: begin
        if (sts.div_done) begin
          cmd.cap_x     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_Y;
          state_next    = S_CY;
        end
      end
      S_CY: begin
        if (sts.div_done) begin
          cmd.cap_yz = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: state_next = S_ACC;
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.need_recip) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_RECIP;
          state_next    = S_RWAIT;
        end else begin
          cmd.nb_step = 1'b1;
          state_next  = sts.nb_last ? S_FINAL : S_ISSUE;
        end
      end
      S_RWAIT: begin
        if (sts.div_done) begin
          cmd.recip_add = 1'b1;
          cmd.nb_step   = 1'b1;
          state_next    = sts.nb_last ? S_FINAL : S_ISSUE;
        end
      end
      S_FINAL: begin
        cmd.prod = 1'b1;
        case (sts.mode)
          MODE_HOT: begin
            if (sts.lone) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_V;
              state_next   = S_EMIT;
            end else begin
              state_next = S_HCMP;
            end
          end
          MODE_HARM: begin
            if (sts.npos_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              state_next   = S_EMIT;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_op    = DIV_FINAL;
              state_next    = S_FWAIT;
            end
          end
          default: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_FINAL;
            state_next    = S_FWAIT;
          end
        endcase
      end
      S_HCMP: begin
        if (sts.hot) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_FINAL;
          state_next    = S_FWAIT;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_V;
          state_next   = S_EMIT;
        end
      end
      S_FWAIT: begin
        if (sts.div_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_QUOT;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> state == S_IDLE)
    else $error("item taken outside idle");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result written over a waiting beat");
  a_issue_acc: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |=> state == S_ACC)
    else $error("store read not followed by accumulate");
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> item_stall)
    else $error("item taken before grid size settled");
`endif

endmodule

@@ design/voxel_neighbourhood_smoother_unit.sv @@
// top level of the 3x3x3 voxel smoother
// depends on vns_pkg, vns_ctrl, vns_dp
// A load beat writes the next voxel of the volume (raster order, x fastest)
// into the 32768 x 16 voxel store. A compute beat produces one filtered voxel
// in raster order; its latency is set by the single shift-subtract divider
// and the one-port store read: two divides split the index into x/y/z, a
// setup step follows, each neighbor (1 to 27 neighbors) is read and summed,
// and decision states pick the result, with a final divide where the mode
// and its checks call for it. In harmonic mode each positive neighbor also
// needs a divide for its reciprocal. One item is in work at a time; a
// finished result waits in the output register while the next beat is taken.
// After reset and after a configuration write the input stalls while the
// grid size settles.
module voxel_neighbourhood_smoother_unit import vns_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  command,
  input  logic [VOX_W-1:0]      voxel_value,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [VOX_W-1:0]      smoothed_value,
  output logic                  last_voxel,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  vns_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .command    (command),
    .cfg_write  (cfg_write),
    .sts        (sts),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  vns_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .voxel_value    (voxel_value),
    .cmd            (cmd),
    .sts            (sts),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .smoothed_value (smoothed_value),
    .last_voxel     (last_voxel)
  );

endmodule
